/* design/assert_macros.svh */
// Assertion macros for the splitter RTL.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check on an explicit clock and active-low reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the house clock and reset names
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_ON_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

/* design/gpbs_pkg.sv */
// Types, constants and helpers for the greedy page break splitter.
// No dependencies; imported by gpbs_step and the top level.
`timescale 1ns / 1ps
`default_nettype none
package gpbs_pkg;

  localparam int unsigned HeightBits = 24;
  localparam logic [HeightBits-1:0] HeightReset = 24'd1024;

  typedef enum logic [1:0] {
    SPLIT_AUTO   = 2'd0,
    SPLIT_ALWAYS = 2'd1,
    SPLIT_AVOID  = 2'd2
  } split_rule_e;

  // Run control that travels between the state registers and the step logic
  typedef struct packed {
    logic       page_open;
    logic       aborted;
    logic [1:0] prev_after;
  } gpbs_ctrl_t;

  // Avoid wins over always; the unused code counts as auto
  function automatic split_rule_e gpbs_combine(input logic [1:0] a, input logic [1:0] b);
    split_rule_e r;
    r = SPLIT_AUTO;
    if (a == SPLIT_AVOID || b == SPLIT_AVOID) begin
      r = SPLIT_AVOID;
    end else if (a == SPLIT_ALWAYS || b == SPLIT_ALWAYS) begin
      r = SPLIT_ALWAYS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/gpbs_step.sv */
// Next-state and page result logic for one registered item.
// Depends on gpbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpbs_step import gpbs_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PAGE_COUNT_BITS = 16
) (
  input  gpbs_ctrl_t                 ctrl_i,
  input  logic [COORD_BITS-1:0]      cur_top_i,
  input  logic [COORD_BITS-1:0]      prev_bottom_i,
  input  logic [PAGE_COUNT_BITS-1:0] count_i,
  input  logic [HeightBits-1:0]      page_height_i,
  input  logic                       action_i,
  input  logic [COORD_BITS-1:0]      line_top_i,
  input  logic [COORD_BITS-1:0]      line_bottom_i,
  input  logic [1:0]                 break_before_i,
  input  logic [1:0]                 break_after_i,
  output gpbs_ctrl_t                 ctrl_o,
  output logic [COORD_BITS-1:0]      cur_top_o,
  output logic [COORD_BITS-1:0]      prev_bottom_o,
  output logic [PAGE_COUNT_BITS-1:0] count_o,
  output logic                       emit_o,
  output logic [COORD_BITS-1:0]      page_top_o,
  output logic [COORD_BITS-1:0]      page_length_o,
  output logic [PAGE_COUNT_BITS-1:0] page_number_o
);

  localparam int unsigned SumBits = ((COORD_BITS > HeightBits) ? COORD_BITS : HeightBits) + 1;
  localparam logic [PAGE_COUNT_BITS-1:0] CountMax = {PAGE_COUNT_BITS{1'b1}};

  logic [SumBits-1:0] limit;
  logic               fits;
  split_rule_e        rule;

  assign limit = SumBits'(cur_top_i) + SumBits'(page_height_i);
  assign fits  = SumBits'(line_bottom_i) <= limit;
  assign rule  = gpbs_combine(ctrl_i.prev_after, break_before_i);

  assign page_top_o    = cur_top_i;
  assign page_length_o = prev_bottom_i - cur_top_i;
  assign page_number_o = count_i;

  always_comb begin
    ctrl_o        = ctrl_i;
    cur_top_o     = cur_top_i;
    prev_bottom_o = prev_bottom_i;
    emit_o        = 1'b0;
    if (action_i) begin
      emit_o        = ctrl_i.page_open && !ctrl_i.aborted;
      ctrl_o        = '{page_open: 1'b0, aborted: 1'b0, prev_after: SPLIT_AUTO};
      cur_top_o     = '0;
      prev_bottom_o = '0;
    end else if (!ctrl_i.aborted) begin
      if (!ctrl_i.page_open) begin
        ctrl_o.page_open  = 1'b1;
        cur_top_o         = line_top_i;
        prev_bottom_o     = line_bottom_i;
        ctrl_o.prev_after = break_after_i;
      end else if (line_top_i < prev_bottom_i) begin
        ctrl_o.aborted = 1'b1;
      end else begin
        if (!fits || rule == SPLIT_ALWAYS) begin
          emit_o    = 1'b1;
          cur_top_o = line_top_i;
        end
        prev_bottom_o     = line_bottom_i;
        ctrl_o.prev_after = break_after_i;
      end
    end
  end

  // Saturate the page counter
  assign count_o = (emit_o && count_i != CountMax) ? count_i + 1'b1 : count_i;

endmodule
`default_nettype wire

/* design/greedy_page_break_splitter.sv */
// Greedy page break splitter: top level with input, run state and result registers.
// Depends on gpbs_pkg, gpbs_step and assert_macros.svh.
//
// Usage:
//   Lines enter on the input channel (in_valid_i / in_ready_o) one transaction
//   at a time; action_i high marks a finish transaction that flushes the open page.
//   Pages leave on the output channel (out_valid_o / out_ready_i), at most one
//   per input transaction, in order.
//   An accepted item is held in the input register, evaluated from there and,
//   if it closes a page, loaded into the result register that drives out_valid_o.
//   Throughput: one item per cycle while the result register is free; the single
//   step through gpbs_step (one add, two compares) sets that figure.
//   A stalled receiver holds the result register; the input register still
//   advances while the result register is empty or being drained, so the input
//   stops only once both stages are full.
//   page_height is written through cfg_valid_i / cfg_data_i, always ready; write
//   it only while no transaction is in flight.
//   Reset clears the run state, the page counter and both valid flags and loads
//   a page height of 1024.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module greedy_page_break_splitter import gpbs_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PAGE_COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [HeightBits-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [COORD_BITS-1:0]      line_top_i,
  input  logic [COORD_BITS-1:0]      line_bottom_i,
  input  logic [1:0]                 break_before_i,
  input  logic [1:0]                 break_after_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [COORD_BITS-1:0]      page_top_o,
  output logic [COORD_BITS-1:0]      page_length_o,
  output logic [PAGE_COUNT_BITS-1:0] page_number_o
);

  // Configuration
  logic [HeightBits-1:0] page_height_q;

  // Input register
  logic                  in_valid_q;
  logic                  action_q;
  logic [COORD_BITS-1:0] line_top_q;
  logic [COORD_BITS-1:0] line_bottom_q;
  logic [1:0]            break_before_q;
  logic [1:0]            break_after_q;

  // Run state
  gpbs_ctrl_t                 ctrl_q, ctrl_d;
  logic [COORD_BITS-1:0]      cur_top_q, cur_top_d;
  logic [COORD_BITS-1:0]      prev_bottom_q, prev_bottom_d;
  logic [PAGE_COUNT_BITS-1:0] count_q, count_d;

  // Result register
  logic                       out_valid_q;
  logic [COORD_BITS-1:0]      page_top_q, page_top_d;
  logic [COORD_BITS-1:0]      page_length_q, page_length_d;
  logic [PAGE_COUNT_BITS-1:0] page_number_q, page_number_d;

  logic emit;
  logic out_free;
  logic step_fire;
  logic live_run;

  assign cfg_ready_o = 1'b1;

  // Result slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_fire  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign live_run   = ctrl_q.page_open && !ctrl_q.aborted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_height_q <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_height_q <= cfg_data_i;
    end
  end

  // Hold the item while the step is blocked by a stalled result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q       <= action_i;
      line_top_q     <= line_top_i;
      line_bottom_q  <= line_bottom_i;
      break_before_q <= break_before_i;
      break_after_q  <= break_after_i;
    end
  end

  gpbs_step #(
    .COORD_BITS      (COORD_BITS),
    .PAGE_COUNT_BITS (PAGE_COUNT_BITS)
  ) u_step (
    .ctrl_i        (ctrl_q),
    .cur_top_i     (cur_top_q),
    .prev_bottom_i (prev_bottom_q),
    .count_i       (count_q),
    .page_height_i (page_height_q),
    .action_i      (action_q),
    .line_top_i    (line_top_q),
    .line_bottom_i (line_bottom_q),
    .break_before_i(break_before_q),
    .break_after_i (break_after_q),
    .ctrl_o        (ctrl_d),
    .cur_top_o     (cur_top_d),
    .prev_bottom_o (prev_bottom_d),
    .count_o       (count_d),
    .emit_o        (emit),
    .page_top_o    (page_top_d),
    .page_length_o (page_length_d),
    .page_number_o (page_number_d)
  );

  // Advance the run state once per evaluated item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q        <= '{page_open: 1'b0, aborted: 1'b0, prev_after: SPLIT_AUTO};
      cur_top_q     <= '0;
      prev_bottom_q <= '0;
      count_q       <= '0;
    end else if (step_fire) begin
      ctrl_q        <= ctrl_d;
      cur_top_q     <= cur_top_d;
      prev_bottom_q <= prev_bottom_d;
      count_q       <= count_d;
    end
  end

  // Load a closed page, drop the flag once the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      page_top_q    <= page_top_d;
      page_length_q <= page_length_d;
      page_number_q <= page_number_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign page_top_o    = page_top_q;
  assign page_length_o = page_length_q;
  assign page_number_o = page_number_q;

  `ASSERT_DEF(a_abort_needs_page, ctrl_q.aborted |-> ctrl_q.page_open, "abort without page")
  `ASSERT_DEF(a_emit_from_open, (step_fire && emit && !action_q) |-> live_run, "emit outside run")
  `ASSERT_DEF(a_count_monotonic, 1'b1 |=> (count_q >= $past(count_q)), "counter went backwards")
  `ASSERT_DEF(a_result_from_step, $rose(out_valid_q) |-> $past(step_fire && emit), "stray result")

endmodule
`default_nettype wire
